FILE: hw/rtl/layer_owner_table_defines.svh
// ----------------------------------------------------------------------------
// Layer owner table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LAYER_OWNER_TABLE_DEFINES_SVH
`define LAYER_OWNER_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LOT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("layer_owner_table: same-cycle check failed");
// next-cycle implication
`define LOT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("layer_owner_table: next-cycle check failed");
`else
`define LOT_ASSERT_IMP(label, ante, cons)
`define LOT_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/lot_pkg.sv
// ----------------------------------------------------------------------------
// Layer owner table package
// Table size, field widths and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lot_pkg;

  // number of table slots (1 to 16)
  localparam int ENTRIES = 6;

  localparam int CMD_W   = 2;
  localparam int LAYER_W = 8;
  localparam int POS_W   = 8;
  localparam int STAMP_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef logic [LAYER_W-1:0] layer_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [ENTRIES-1:0] slot_vec_t;

endpackage

`default_nettype wire

FILE: hw/rtl/layer_owner_table.sv
// ----------------------------------------------------------------------------
// Layer owner table
// Records which key and which keyboard half holds each layer; answers queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: press
//   records layer, key position and side; release frees the lowest matching
//   slot; query asks for the side of the newest slot holding a layer.
//   Output channel (out_valid / out_stall) carries one beat per query only:
//   out_found and out_owner_is_right.
//   Path: an accepted query beat passes the input register, then the
//   result register, where out_found and out_owner_is_right are held.
//   Throughput: one beat per cycle while in_stall is low; all slots are
//   compared in parallel in the single stage between the input and the
//   table/result registers, so that compare network sets the clock period.
//   Stall: while a result waits under out_stall, presses and releases still
//   go through; a query in the input register holds and in_stall rises.
//   Reset (rst_n low, synchronous): all slots free, stamp counter zero, both
//   channels empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "layer_owner_table_defines.svh"

module layer_owner_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lot_pkg::CMD_W-1:0]   in_command,
  input  wire logic [lot_pkg::LAYER_W-1:0] in_layer,
  input  wire logic [lot_pkg::POS_W-1:0]   in_key_position,
  input  wire logic                        in_right_hand,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_found,
  output logic                             out_owner_is_right
);

  // input register
  logic                 in_vld_r, in_vld_nxt;
  lot_pkg::cmd_t        cmd_r;
  lot_pkg::layer_t      layer_r;
  lot_pkg::pos_t        pos_r;
  logic                 side_r;

  // table
  lot_pkg::layer_t      entry_layer_r [lot_pkg::ENTRIES];
  lot_pkg::pos_t        entry_pos_r   [lot_pkg::ENTRIES];
  logic                 entry_side_r  [lot_pkg::ENTRIES];
  lot_pkg::stamp_t      entry_stamp_r [lot_pkg::ENTRIES];
  lot_pkg::stamp_t      entry_stamp_nxt [lot_pkg::ENTRIES];
  lot_pkg::stamp_t      stamp_cnt_r, stamp_cnt_nxt;

  // result register
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_right_r, out_right_nxt;

  // slot selection
  lot_pkg::slot_vec_t   free_v, free_first, is_min, victim_sel;
  lot_pkg::slot_vec_t   rel_match, rel_first, cand, query_win;
  logic                 proc_go, is_press, is_release, is_query;

  assign is_press   = (cmd_r == lot_pkg::CMD_PRESS);
  assign is_release = (cmd_r == lot_pkg::CMD_RELEASE);
  assign is_query   = (cmd_r == lot_pkg::CMD_QUERY);

  // process the held beat unless it is a query blocked by a waiting result
  assign proc_go  = in_vld_r && (!is_query || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !proc_go;

  // compare every slot against every other in parallel
  always_comb begin
    for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
      free_v[i]    = (entry_stamp_r[i] == '0);
      rel_match[i] = !free_v[i] && (entry_layer_r[i] == layer_r) &&
                     (entry_pos_r[i] == pos_r);
      cand[i]      = !free_v[i] && (entry_layer_r[i] == layer_r);
    end
    for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
      free_first[i] = free_v[i];
      rel_first[i]  = rel_match[i];
      is_min[i]     = 1'b1;
      query_win[i]  = cand[i];
      for (int j = 0; j < lot_pkg::ENTRIES; j++) begin
        if (j < i) begin
          if (free_v[j])    free_first[i] = 1'b0;
          if (rel_match[j]) rel_first[i]  = 1'b0;
          if (!(entry_stamp_r[i] < entry_stamp_r[j])) is_min[i] = 1'b0;
          if (cand[j] && !(entry_stamp_r[i] > entry_stamp_r[j])) query_win[i] = 1'b0;
        end else if (j > i) begin
          if (!(entry_stamp_r[i] <= entry_stamp_r[j])) is_min[i] = 1'b0;
          if (cand[j] && !(entry_stamp_r[i] >= entry_stamp_r[j])) query_win[i] = 1'b0;
        end
      end
    end
    victim_sel = (|free_v) ? free_first : is_min;
  end

  // next state of stamps, counter and result
  always_comb begin
    stamp_cnt_nxt = stamp_cnt_r;
    for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
      entry_stamp_nxt[i] = entry_stamp_r[i];
    end
    if (proc_go && is_press) begin
      stamp_cnt_nxt = stamp_cnt_r + lot_pkg::STAMP_W'(1);
      for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
        if (victim_sel[i]) entry_stamp_nxt[i] = stamp_cnt_nxt;
      end
    end else if (proc_go && is_release) begin
      for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
        if (rel_first[i]) entry_stamp_nxt[i] = '0;
      end
    end

    out_vld_nxt   = out_vld_r && out_stall;
    out_found_nxt = out_found_r;
    out_right_nxt = out_right_r;
    if (proc_go && is_query) begin
      out_vld_nxt   = 1'b1;
      out_found_nxt = |cand;
      out_right_nxt = 1'b0;
      for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
        if (query_win[i] && entry_side_r[i]) out_right_nxt = 1'b1;
      end
    end

    in_vld_nxt = in_valid || (in_vld_r && !proc_go);
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      stamp_cnt_r <= '0;
      for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
        entry_stamp_r[i] <= '0;
      end
    end else begin
      in_vld_r    <= in_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
        entry_stamp_r[i] <= entry_stamp_nxt[i];
      end
    end
  end

  // load payload: input beat, slot contents, result fields
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      cmd_r   <= lot_pkg::cmd_t'(in_command);
      layer_r <= in_layer;
      pos_r   <= in_key_position;
      side_r  <= in_right_hand;
    end
    if (proc_go && is_press) begin
      for (int i = 0; i < lot_pkg::ENTRIES; i++) begin
        if (victim_sel[i]) begin
          entry_layer_r[i] <= layer_r;
          entry_pos_r[i]   <= pos_r;
          entry_side_r[i]  <= side_r;
        end
      end
    end
    out_found_r <= out_found_nxt;
    out_right_r <= out_right_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_found          = out_found_r;
  assign out_owner_is_right = out_right_r;

  // checks
  `LOT_ASSERT_NXT(a_query_gives_beat, proc_go && is_query, out_valid)
  `LOT_ASSERT_IMP(a_not_found_left, out_valid && !out_found, !out_owner_is_right)
  `LOT_ASSERT_IMP(a_one_victim, proc_go && is_press, $onehot(victim_sel))
  `LOT_ASSERT_IMP(a_single_winner, in_vld_r, $onehot0(query_win))
  `LOT_ASSERT_NXT(a_stamp_step, proc_go && is_press, stamp_cnt_r == $past(stamp_cnt_r) + 1)

endmodule

`default_nettype wire

FILE: verif/layer_owner_table_checker.sv
// ----------------------------------------------------------------------------
// Layer owner table checker
// Watches both channels of the layer owner table and keeps its own copy of the
// slot table. Every accepted command beat is applied to that copy. Each query
// queues the owner it should report, and each accepted result beat is compared
// field by field with the oldest queued owner.
// ----------------------------------------------------------------------------
module layer_owner_table_checker
  import lot_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [LAYER_W-1:0] in_layer,
  input  logic [POS_W-1:0]   in_key_position,
  input  logic               in_right_hand,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_found,
  input  logic               out_owner_is_right,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic found;
    logic owner_is_right;
  } owner_result_t;

  // shadow slot table; a zero stamp marks a free slot
  layer_t slot_layer [ENTRIES];
  pos_t   slot_pos   [ENTRIES];
  logic   slot_side  [ENTRIES];
  stamp_t slot_stamp [ENTRIES];
  stamp_t stamp_now;

  owner_result_t expected_owner [$];
  owner_result_t want;

  task automatic report_mismatch(input string what);
    $display("%0t layer_owner_table_checker: %s", $time, what);
    errors++;
  endtask

  // store in the lowest free slot, else over the oldest stamp (lowest index on a tie)
  function automatic void record_press(input layer_t lay, input pos_t pos, input logic side);
    int  victim;
    bit  have;
    victim = 0;
    have   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!have && slot_stamp[i] == '0) begin
        victim = i;
        have   = 1'b1;
      end
    end
    if (!have) begin
      for (int i = 1; i < ENTRIES; i++) begin
        if (slot_stamp[i] < slot_stamp[victim]) victim = i;
      end
    end
    stamp_now          = stamp_now + 1'b1;
    slot_layer[victim] = lay;
    slot_pos[victim]   = pos;
    slot_side[victim]  = side;
    slot_stamp[victim] = stamp_now;
  endfunction

  // free the lowest-index active slot that matches layer and position
  function automatic void drop_holder(input layer_t lay, input pos_t pos);
    bit done;
    done = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!done && slot_stamp[i] != '0 && slot_layer[i] == lay && slot_pos[i] == pos) begin
        slot_stamp[i] = '0;
        done          = 1'b1;
      end
    end
  endfunction

  // side of the newest active slot for the layer; lowest index wins on equal stamps
  function automatic owner_result_t lookup_owner(input layer_t lay);
    owner_result_t r;
    int            best;
    bit            have;
    best = 0;
    have = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_stamp[i] != '0 && slot_layer[i] == lay &&
          (!have || slot_stamp[i] > slot_stamp[best])) begin
        best = i;
        have = 1'b1;
      end
    end
    r.found          = have;
    r.owner_is_right = have ? slot_side[best] : 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_stamp[i] = '0;
      stamp_now = '0;
      expected_owner.delete();
    end else begin
      // compare a result beat with the oldest waiting owner
      if (out_valid && !out_stall) begin
        if (expected_owner.size() == 0) begin
          report_mismatch($sformatf("result beat with no query waiting (found %0b right %0b)",
                                    out_found, out_owner_is_right));
        end else begin
          want = expected_owner.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("found: got %0b, want %0b", out_found, want.found));
          if (out_owner_is_right !== want.owner_is_right)
            report_mismatch($sformatf("owner_is_right: got %0b, want %0b",
                                      out_owner_is_right, want.owner_is_right));
        end
      end
      // advance the shadow table on a command beat
      if (in_valid && !in_stall) begin
        case (cmd_t'(in_command))
          CMD_PRESS:   record_press(in_layer, in_key_position, in_right_hand);
          CMD_RELEASE: drop_holder(in_layer, in_key_position);
          CMD_QUERY:   expected_owner.push_back(lookup_owner(in_layer));
          default: ;
        endcase
      end
    end
    pending = expected_owner.size();
  end

endmodule

FILE: verif/layer_owner_table_tb.sv
// ----------------------------------------------------------------------------
// Layer owner table testbench
// Drives press, release and query beats into the table: a directed opening
// over empty, full and duplicate cases, then randomised hold sequences with
// noise under several idle and stall mixes. It also runs a long receiver
// hold-off that backs the block up. The checker beside the block predicts
// and compares.
// ----------------------------------------------------------------------------
module layer_owner_table_tb;
  import lot_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_command         = '0;
  logic [LAYER_W-1:0] in_layer           = '0;
  logic [POS_W-1:0]   in_key_position    = '0;
  logic               in_right_hand      = 1'b0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic               out_found;
  logic               out_owner_is_right;

  int errors;
  int pending;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_cycles;
  int commands_sent;
  int phase_end;
  int quiet_cycles;

  layer_t layer_pool [7] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd254, 8'd255};
  pos_t   pos_pool   [3] = '{8'd0, 8'd1, 8'd255};

  layer_owner_table u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_layer           (in_layer),
    .in_key_position    (in_key_position),
    .in_right_hand      (in_right_hand),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_owner_is_right (out_owner_is_right)
  );

  layer_owner_table_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_layer           (in_layer),
    .in_key_position    (in_key_position),
    .in_right_hand      (in_right_hand),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_owner_is_right (out_owner_is_right),
    .errors             (errors),
    .pending            (pending)
  );

  always #5 clk = ~clk;

  // receiver: a requested hold-off first, otherwise random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("layer_owner_table_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one command beat, with random idle cycles ahead of it; hold until taken
  task automatic send_beat(input cmd_t cmd, input layer_t lay, input pos_t pos,
                           input logic side);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_layer        <= lay;
    in_key_position <= pos;
    in_right_hand   <= side;
    do @(posedge clk); while (in_stall);
    if (cmd != CMD_NOP) commands_sent++;
  endtask

  // drop valid and wait until every query has been answered
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic layer_t pick_layer();
    return ($urandom_range(9) < 7) ? layer_pool[$urandom_range(6)] : layer_t'($urandom);
  endfunction

  function automatic pos_t pick_pos();
    return ($urandom_range(3) < 3) ? pos_pool[$urandom_range(2)] : pos_t'($urandom);
  endfunction

  // press a key, ask about its layer, maybe press another, maybe release the first and ask again
  task automatic hold_sequence();
    layer_t lay;
    pos_t   pos;
    logic   side;
    lay  = pick_layer();
    pos  = pick_pos();
    side = 1'($urandom_range(1));
    send_beat(CMD_PRESS, lay, pos, side);
    send_beat(CMD_QUERY, lay, pos_t'($urandom), 1'($urandom_range(1)));
    if ($urandom_range(1))
      send_beat(CMD_PRESS, pick_layer(), pick_pos(), 1'($urandom_range(1)));
    if ($urandom_range(99) < 60) begin
      send_beat(CMD_RELEASE, lay, pos, 1'($urandom_range(1)));
      send_beat(CMD_QUERY, lay, pos_t'($urandom), 1'($urandom_range(1)));
    end
  endtask

  task automatic random_phase(input int count);
    phase_end = commands_sent + count;
    while (commands_sent < phase_end) begin
      if ($urandom_range(99) < 80) begin
        hold_sequence();
      end else begin
        send_beat(cmd_t'($urandom_range(3)), layer_t'($urandom), pos_t'($urandom),
                  1'($urandom_range(1)));
      end
      if (commands_sent >= phase_end - count / 2 && commands_sent < phase_end - count / 2 + 5)
        drain_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, eviction when full
    send_beat(CMD_QUERY,   8'd0,   8'd0,   1'b0);
    send_beat(CMD_NOP,     8'd255, 8'd255, 1'b1);
    send_beat(CMD_PRESS,   8'd0,   8'd0,   1'b0);
    send_beat(CMD_PRESS,   8'd255, 8'd255, 1'b1);
    send_beat(CMD_QUERY,   8'd255, 8'd0,   1'b0);
    send_beat(CMD_QUERY,   8'd0,   8'd255, 1'b1);
    send_beat(CMD_PRESS,   8'd5,   8'd10,  1'b1);
    send_beat(CMD_PRESS,   8'd5,   8'd10,  1'b0);
    send_beat(CMD_QUERY,   8'd5,   8'd0,   1'b0);
    send_beat(CMD_RELEASE, 8'd5,   8'd10,  1'b0);
    send_beat(CMD_QUERY,   8'd5,   8'd0,   1'b0);
    send_beat(CMD_RELEASE, 8'd5,   8'd10,  1'b0);
    send_beat(CMD_QUERY,   8'd5,   8'd0,   1'b0);
    send_beat(CMD_RELEASE, 8'd7,   8'd1,   1'b0);
    for (int i = 1; i <= 6; i++)
      send_beat(CMD_PRESS, 8'd9, pos_t'(i), logic'(i % 2));
    send_beat(CMD_QUERY,   8'd0,   8'd0,   1'b0);
    send_beat(CMD_QUERY,   8'd9,   8'd0,   1'b0);
    send_beat(CMD_PRESS,   8'd9,   8'd7,   1'b1);
    send_beat(CMD_QUERY,   8'd9,   8'd0,   1'b0);
    drain_results();

    // free-running phase, then a long receiver hold-off under a flood of queries
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    random_phase(260);
    hold_cycles = 150;
    for (int i = 0; i < 30; i++)
      send_beat((i % 3 == 0) ? CMD_PRESS : CMD_QUERY, pick_layer(), pick_pos(),
                1'($urandom_range(1)));
    drain_results();

    sender_idle_pct    = 69;
    receiver_stall_pct = 0;
    random_phase(270);

    sender_idle_pct    = 0;
    receiver_stall_pct = 69;
    random_phase(270);

    sender_idle_pct    = 7;
    receiver_stall_pct = 7;
    random_phase(270);

    // let the last results come out, then a few more cycles for stray beats
    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("layer_owner_table_tb: done, clean");
    else
      $display("layer_owner_table_tb: done, errors");
    $finish;
  end

endmodule

FILE: layer_owner_table.f
+incdir+hw/rtl
hw/rtl/lot_pkg.sv
hw/rtl/layer_owner_table.sv
verif/layer_owner_table_checker.sv
verif/layer_owner_table_tb.sv
